// ----- rtl/vlc_pkg.sv -----
// Package for the vertex layout checker: shared types, error codes,
// format size table and default constants. No dependencies.
package vlc_pkg;

  localparam int MAX_ATTR_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int OFF_W        = 31;  // running offset never exceeds INT32_MAX

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NEG_STRD  = 3'd1,
    ERR_TOO_MANY  = 3'd2,
    ERR_BAD_VALUE = 3'd3,
    ERR_LOC_CLASH = 3'd4,
    ERR_BAD_FMT   = 3'd5,
    ERR_OVERFLOW  = 3'd6
  } err_code_t;

  // One attribute descriptor request
  typedef struct packed {
    logic [3:0]               format_code;
    logic signed [DATA_W-1:0] attr_offset;
    logic signed [DATA_W-1:0] attr_location;
    logic                     last;
  } attr_req_t;

  // One verdict
  typedef struct packed {
    logic      layout_ok;
    err_code_t error_code;
    logic      done_res;
  } verdict_t;

  // Bytes per format code; zero marks an invalid code
  function automatic logic [4:0] fmt_size(input logic [3:0] code);
    logic [4:0] sz;
    unique case (code)
      4'd0, 4'd1, 4'd2, 4'd3: sz = 5'd4;
      4'd4:                   sz = 5'd8;
      4'd5:                   sz = 5'd12;
      4'd6:                   sz = 5'd16;
      default:                sz = 5'd0;
    endcase
    return sz;
  endfunction

endpackage

// ----- rtl/vlc_if.sv -----
// Channel interfaces for the vertex layout checker: descriptor input,
// verdict output and stride write port. Depends on vlc_pkg.
interface vlc_in_if import vlc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [3:0]               format_code;
  logic signed [DATA_W-1:0] attr_offset;
  logic signed [DATA_W-1:0] attr_location;
  logic                     last;

  modport source (output valid, format_code, attr_offset, attr_location, last,
                  input ready);
  modport sink   (input valid, format_code, attr_offset, attr_location, last,
                  output ready);
endinterface

interface vlc_out_if ();
  logic       valid;
  logic       ready;
  logic       layout_ok;
  logic [2:0] error_code;
  logic       done_res;

  modport source (output valid, layout_ok, error_code, done_res, input ready);
  modport sink   (input valid, layout_ok, error_code, done_res, output ready);
endinterface

interface vlc_cfg_if import vlc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] buffer_stride;

  modport source (output valid, buffer_stride, input ready);
  modport sink   (input valid, buffer_stride, output ready);
endinterface

// ----- rtl/vertex_layout_checker_top.sv -----
// Top level of the vertex layout checker. Depends on vlc_pkg, vlc_if,
// vlc_in_stage, vlc_check and vlc_out_stage.
//
// Usage:
//   in_if  : one attribute descriptor request per accepted item, with last
//            on the final attribute of a layout.
//   out_if : one verdict per request (layout_ok, first error code,
//            done_res copying last).
//   cfg_if : writes buffer_stride; always ready; write only while idle.
// Path: a request accepted into the input register has its verdict
//   registered in the result register when that register is free.
// Throughput: one request per cycle while out_if.ready is high; the
//   location check and offset add work against the layout state
//   combinationally between the input and result registers.
// Stall: while out_if.ready is low the result register holds its verdict;
//   the input register takes one more request only if it is empty, and
//   in_if.ready stays low once it holds a request.
// Reset: both registers empty, stride zero, layout state cleared. The
//   layout state also clears after each request marked last.
module vertex_layout_checker_top
  import vlc_pkg::*;
#(
  parameter int MAX_ATTRIBUTES = MAX_ATTR_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vlc_in_if.sink    in_if,
  vlc_out_if.source out_if,
  vlc_cfg_if.sink   cfg_if
);

  logic      req_valid;
  attr_req_t req;
  verdict_t  res;
  logic      res_ready;
  logic      adv;

  // Held request moves into the result register
  assign adv = req_valid && res_ready;

  vlc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req)
  );

  vlc_check #(
    .MAX_ATTRIBUTES (MAX_ATTRIBUTES)
  ) u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .adv    (adv),
    .req    (req),
    .res    (res)
  );

  vlc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (req_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_if    (out_if)
  );

endmodule

// ----- rtl/vlc_in_stage.sv -----
// Input register of the vertex layout checker: captures one descriptor
// request per cycle when not stalled. Depends on vlc_pkg, vlc_if.
module vlc_in_stage
  import vlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  vlc_in_if.sink    in_if,
  input  logic      adv,       // held request moves on this cycle
  output logic      req_valid,
  output attr_req_t req
);

  logic      valid_r;
  attr_req_t req_r;

  // Take a new request when empty or when the held one leaves
  assign in_if.ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      req_r.format_code   <= in_if.format_code;
      req_r.attr_offset   <= in_if.attr_offset;
      req_r.attr_location <= in_if.attr_location;
      req_r.last          <= in_if.last;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

// ----- rtl/vlc_check.sv -----
// Rule checks and layout state of the vertex layout checker: location
// bitmap, running offset, index, sticky error, stride register.
// Depends on vlc_pkg and vlc_if.
module vlc_check
  import vlc_pkg::*;
#(
  parameter int MAX_ATTRIBUTES = MAX_ATTR_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vlc_cfg_if.sink   cfg_if,
  input  logic      adv,   // commit the held request
  input  attr_req_t req,
  output verdict_t  res
);

  localparam int IDX_W = $clog2(MAX_ATTRIBUTES + 1);
  localparam int LOC_W = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
  localparam int LOC_N = 1 << LOC_W;

  logic signed [DATA_W-1:0]  stride_r;
  logic [MAX_ATTRIBUTES-1:0] used_r, used_nxt;
  logic [OFF_W-1:0]          run_off_r, run_off_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  err_code_t                 ferr_r, ferr_nxt;

  logic [LOC_N-1:0]  used_pad;
  logic [LOC_W-1:0]  loc_sel;
  logic              off_bad, loc_bad, loc_range_bad, idx_full;
  logic [4:0]        size;
  logic [DATA_W-1:0] base, next_off;
  logic              past_stride;
  err_code_t         chk;

  // Stride register: the user writes it only while idle; not enforced
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= '0;
    end else if (cfg_if.valid) begin
      stride_r <= cfg_if.buffer_stride;
    end
  end

  // Field decode
  assign idx_full      = (idx_r >= IDX_W'(MAX_ATTRIBUTES));
  assign off_bad       = req.attr_offset[DATA_W-1] && (req.attr_offset != '1);
  assign loc_bad       = req.attr_location[DATA_W-1] && (req.attr_location != '1);
  assign loc_range_bad = !req.attr_location[DATA_W-1] &&
                         ($unsigned(req.attr_location) >= DATA_W'(MAX_ATTRIBUTES));
  assign loc_sel       = req.attr_location[DATA_W-1] ? idx_r[LOC_W-1:0]
                                                     : req.attr_location[LOC_W-1:0];
  assign used_pad      = LOC_N'(used_r);
  assign size          = fmt_size(req.format_code);

  // End offset of this attribute; 32 bits hold it without wrap
  assign base        = req.attr_offset[DATA_W-1] ? DATA_W'(run_off_r)
                                                 : $unsigned(req.attr_offset);
  assign next_off    = base + DATA_W'(size);
  assign past_stride = (stride_r > 0) && (next_off > $unsigned(stride_r));

  // Checks in priority order
  always_comb begin
    priority if (stride_r[DATA_W-1])           chk = ERR_NEG_STRD;
    else if (idx_full)                         chk = ERR_TOO_MANY;
    else if (off_bad || loc_bad)               chk = ERR_BAD_VALUE;
    else if (loc_range_bad)                    chk = ERR_BAD_VALUE;
    else if (used_pad[loc_sel])                chk = ERR_LOC_CLASH;
    else if (size == 5'd0)                     chk = ERR_BAD_FMT;
    else if (next_off[DATA_W-1] || past_stride) chk = ERR_OVERFLOW;
    else                                       chk = ERR_NONE;
  end

  // Next layout state
  always_comb begin
    used_nxt    = used_r;
    run_off_nxt = run_off_r;
    ferr_nxt    = ferr_r;
    idx_nxt     = idx_full ? idx_r : idx_r + IDX_W'(1);
    if (ferr_r == ERR_NONE) begin
      ferr_nxt = chk;
      if (chk == ERR_NONE) begin
        used_nxt    = used_r | MAX_ATTRIBUTES'(LOC_N'(1) << loc_sel);
        run_off_nxt = next_off[OFF_W-1:0];
      end
    end
  end

  // Verdict reflects the error state after this request
  assign res.layout_ok  = (ferr_nxt == ERR_NONE);
  assign res.error_code = ferr_nxt;
  assign res.done_res   = req.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      run_off_r <= '0;
      idx_r     <= '0;
      ferr_r    <= ERR_NONE;
    end else if (adv) begin
      if (req.last) begin
        used_r    <= '0;
        run_off_r <= '0;
        idx_r     <= '0;
        ferr_r    <= ERR_NONE;
      end else begin
        used_r    <= used_nxt;
        run_off_r <= run_off_nxt;
        idx_r     <= idx_nxt;
        ferr_r    <= ferr_nxt;
      end
    end
  end

endmodule

// ----- rtl/vlc_out_stage.sv -----
// Result register of the vertex layout checker: holds one verdict until
// the receiver takes it. Depends on vlc_pkg and vlc_if.
module vlc_out_stage
  import vlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_valid,
  input  verdict_t res,
  output logic     res_ready,
  vlc_out_if.source out_if
);

  logic     valid_r;
  verdict_t res_r;

  // Free when empty or when the current verdict is taken
  assign res_ready = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_if.valid      = valid_r;
  assign out_if.layout_ok  = res_r.layout_ok;
  assign out_if.error_code = res_r.error_code;
  assign out_if.done_res   = res_r.done_res;

endmodule

// ----- tb/sv/tb_vertex_layout_checker_top.sv -----
// Self-checking testbench for vertex_layout_checker_top: streams attribute
// descriptor requests, predicts every verdict and compares them in order.
// Depends on vlc_pkg, the vlc channel interfaces and the top-level RTL.
module tb_vertex_layout_checker_top;
  import vlc_pkg::*;

  localparam int MAX_ATTR = MAX_ATTR_DEF;

  logic clk;
  logic rst_n;

  vlc_in_if  in_if ();
  vlc_out_if out_if ();
  vlc_cfg_if cfg_if ();

  vertex_layout_checker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Requests waiting to be sent and verdicts waiting to come back
  attr_req_t pending_reqs[$];
  verdict_t  verdicts_due[$];

  // Shadow of the stride register and of the per-layout state
  longint    cur_stride;
  logic [MAX_ATTR-1:0] lay_used;
  longint    lay_offset;
  int        lay_index;
  err_code_t lay_err;

  // Traffic shaping, set per phase by the sequencer
  int src_mode;
  int rdy_mode;
  int holds_asked;
  int holds_given;

  int fails;
  int layouts_checked;
  int strides_written;
  int err_tally[7];

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #(12 * 2_000_000);
    $display("Timeout waiting for verdicts");
    $display("Some tests failed");
    $finish;
  end

  // Checks one descriptor against the layout state; updates it when clean
  function automatic err_code_t judge_attr(attr_req_t r);
    longint off;
    longint loc;
    longint nxt;
    longint sz;
    off = $signed(r.attr_offset);
    loc = $signed(r.attr_location);
    if (cur_stride < 0) return ERR_NEG_STRD;
    if (lay_index >= MAX_ATTR) return ERR_TOO_MANY;
    if (off < -1 || loc < -1) return ERR_BAD_VALUE;
    if (loc < 0) loc = lay_index;
    if (loc >= MAX_ATTR) return ERR_BAD_VALUE;
    if (lay_used[int'(loc)]) return ERR_LOC_CLASH;
    case (r.format_code)
      4'd0, 4'd1, 4'd2, 4'd3: sz = 4;
      4'd4:                   sz = 8;
      4'd5:                   sz = 12;
      4'd6:                   sz = 16;
      default:                sz = 0;
    endcase
    if (sz == 0) return ERR_BAD_FMT;
    nxt = ((off >= 0) ? off : lay_offset) + sz;
    if (nxt > 64'sd2147483647 || (cur_stride > 0 && nxt > cur_stride))
      return ERR_OVERFLOW;
    lay_used[int'(loc)] = 1'b1;
    lay_offset = nxt;
    return ERR_NONE;
  endfunction

  // Verdict for one accepted request; the first error sticks until last
  function automatic verdict_t predict_verdict(attr_req_t r);
    verdict_t v;
    if (lay_err == ERR_NONE) lay_err = judge_attr(r);
    if (lay_index < MAX_ATTR) lay_index++;
    v.layout_ok  = (lay_err == ERR_NONE);
    v.error_code = lay_err;
    v.done_res   = r.last;
    if (r.last) begin
      lay_used   = '0;
      lay_offset = 0;
      lay_index  = 0;
      lay_err    = ERR_NONE;
    end
    return v;
  endfunction

  // Request driver: gapless or bursty, holds a request until it is taken
  int        burst_left;
  int        gap_left;
  attr_req_t offered;

  always @(posedge clk) begin : drive_reqs
    logic nv;
    nv = in_if.valid;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        verdicts_due.push_back(predict_verdict(offered));
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          offered = pending_reqs.pop_front();
          nv = 1'b1;
          if (src_mode != 0) begin
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 11);
              gap_left   = $urandom_range(1, (src_mode == 2) ? 20 : 5);
            end
          end
        end
      end
      in_if.valid <= nv;
      if (nv) begin
        in_if.format_code   <= offered.format_code;
        in_if.attr_offset   <= offered.attr_offset;
        in_if.attr_location <= offered.attr_location;
        in_if.last          <= offered.last;
      end
    end
  end

  // Verdict monitor and receiver stall pattern
  int hold_left;
  int stall_tick;

  always @(posedge clk) begin : watch_verdicts
    logic     nr;
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdicts_due.size() == 0) begin
        if (fails < 50)
          $display("%0t: unexpected verdict ok=%0b err=%0d done=%0b", $time,
                   out_if.layout_ok, out_if.error_code, out_if.done_res);
        fails++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_if.layout_ok !== want.layout_ok ||
            out_if.error_code !== want.error_code ||
            out_if.done_res !== want.done_res) begin
          if (fails < 50)
            $display({"%0t: verdict mismatch: expected ok=%0b err=%0d done=%0b,",
                      " got ok=%0b err=%0d done=%0b"},
                     $time, want.layout_ok, want.error_code, want.done_res,
                     out_if.layout_ok, out_if.error_code, out_if.done_res);
          fails++;
        end else if (want.done_res) begin
          layouts_checked++;
          err_tally[want.error_code]++;
        end
      end
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (rst_n && holds_asked > holds_given) begin
      holds_given++;
      hold_left = 80;
      nr = 1'b0;
    end else begin
      case (rdy_mode)
        0:       nr = 1'b1;
        1:       nr = ($urandom_range(0, 3) != 0);
        default: nr = ((stall_tick % 11) < 7);
      endcase
    end
    out_if.ready <= nr;
  end

  task automatic add_req(input logic [3:0] fmt, input int off, input int loc,
                         input logic lst);
    attr_req_t r;
    r.format_code   = fmt;
    r.attr_offset   = off;
    r.attr_location = loc;
    r.last          = lst;
    pending_reqs.push_back(r);
  endtask

  // Waits until nothing is queued, offered or outstanding
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || verdicts_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_stride(input int s);
    @(posedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.buffer_stride <= s;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cur_stride = s;
    strides_written++;
    cfg_if.valid <= 1'b0;
  endtask

  // One random layout: mostly well formed, some broken, some pure noise
  task automatic queue_layout();
    int kind;
    int n;
    int j;
    int t;
    int perm[16];
    attr_req_t r;
    kind = $urandom_range(0, 9);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
    for (int i = 0; i < 16; i++) perm[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < n; i++) begin
      r.format_code   = 4'($urandom_range(0, 6));
      r.attr_offset   = -1;
      r.attr_location = (kind < 3) ? -1 : perm[i % 16];
      if ($urandom_range(0, 3) == 0) r.attr_offset = $urandom_range(0, 256);
      if (kind == 7 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: r.format_code   = 4'($urandom_range(7, 15));
          1: r.attr_location = perm[0];
          2: r.attr_offset   = -2 - $urandom_range(0, 5);
          default: r.attr_location = $urandom_range(16, 40);
        endcase
      end
      if (kind >= 8) begin
        r.format_code = 4'($urandom);
        case ($urandom_range(0, 3))
          0: r.attr_offset = $urandom;
          1: r.attr_offset = $urandom_range(0, 300) - 3;
          2: r.attr_offset = 32'h7fff_fff0 + $urandom_range(0, 15);
          default: r.attr_offset = -1;
        endcase
        r.attr_location = ($urandom_range(0, 2) == 0) ? $urandom
                                                      : $urandom_range(0, 23) - 3;
      end
      r.last = (i == n - 1);
      pending_reqs.push_back(r);
    end
  endtask

  // Sequencer: reset, directed layouts, then random phases
  initial begin : sequencer
    int strides[7];
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.format_code    = '0;
    in_if.attr_offset    = '0;
    in_if.attr_location  = '0;
    in_if.last           = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.buffer_stride = '0;
    cur_stride = 0;
    lay_used   = '0;
    lay_offset = 0;
    lay_index  = 0;
    lay_err    = ERR_NONE;
    src_mode = 0;
    rdy_mode = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Clean layout, every format size, implicit and explicit fields
    add_req(4'd0, -1, -1, 1'b0);
    add_req(4'd4, -1, 5, 1'b0);
    add_req(4'd5, 100, -1, 1'b0);
    add_req(4'd6, -1, 15, 1'b0);
    add_req(4'd3, 0, 1, 1'b1);
    // Location clash, then the error sticks over a bad format
    add_req(4'd1, -1, 3, 1'b0);
    add_req(4'd2, -1, 3, 1'b0);
    add_req(4'd15, -1, -1, 1'b1);
    // Single bad items: format, offset, location values and range
    add_req(4'd7, -1, -1, 1'b1);
    add_req(4'd0, -2, -1, 1'b1);
    add_req(4'd0, -1, -2, 1'b1);
    add_req(4'd0, -1, 16, 1'b1);
    add_req(4'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    // Offset overflow past INT32_MAX
    add_req(4'd0, 32'h7fff_fffc, 0, 1'b1);
    add_req(4'd0, 32'h7fff_fff8, -1, 1'b0);
    add_req(4'd0, -1, -1, 1'b1);
    // Start of a layout that finishes under a new stride
    add_req(4'd0, -1, -1, 1'b0);
    add_req(4'd4, -1, -1, 1'b0);
    wait_idle();
    write_stride(16);
    add_req(4'd0, -1, -1, 1'b0);
    add_req(4'd0, -1, -1, 1'b1);
    wait_idle();
    // Negative stride rejects everything
    write_stride(-1);
    add_req(4'd0, -1, -1, 1'b1);
    wait_idle();

    strides[0] = 0;
    strides[1] = 32'h7fff_ffff;
    strides[2] = 64;
    strides[3] = 32'h8000_0000;
    strides[4] = 200;
    strides[5] = $urandom_range(16, 400);
    strides[6] = 0;
    for (int p = 0; p < 7; p++) begin
      write_stride(strides[p]);
      src_mode = p % 3;
      rdy_mode = (p + 1) % 3;
      while (pending_reqs.size() < 260) queue_layout();
      if (p == 2) begin
        // Long receiver hold while the sender keeps pushing
        src_mode = 0;
        holds_asked++;
      end
      wait_idle();
    end

    repeat (4) @(negedge clk);
    $display("Checked %0d layouts over %0d stride settings with bursty and stalled traffic",
             layouts_checked, strides_written);
    $display("Final verdicts by error code 0..6: %0d %0d %0d %0d %0d %0d %0d",
             err_tally[0], err_tally[1], err_tally[2], err_tally[3],
             err_tally[4], err_tally[5], err_tally[6]);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
